FILE: design/ule_pkg.sv
// Package for the UTF-8 line edit buffer: command codes and shared types.
package ule_pkg;

  typedef enum logic [3:0] {
    CMD_INSERT    = 4'd0,
    CMD_BACKSPACE = 4'd1,
    CMD_DELETE    = 4'd2,
    CMD_HOME      = 4'd3,
    CMD_END       = 4'd4,
    CMD_LEFT      = 4'd5,
    CMD_RIGHT     = 4'd6,
    CMD_BEGIN     = 4'd7,
    CMD_SELALL    = 4'd8,
    CMD_CLEAR     = 4'd9,
    CMD_TRIM      = 4'd10,
    CMD_READ      = 4'd11
  } cmd_t;

  // Shift operations applied to the cell row.
  typedef enum logic [1:0] {
    SH_HOLD  = 2'd0,
    SH_RIGHT = 2'd1,
    SH_LEFT  = 2'd2
  } shift_t;

  // Row control: every cell compares its position against from_pos.
  typedef struct packed {
    shift_t     op;
    logic [16:0] from_pos;
    logic        wr_en;
    logic [16:0] wr_pos;
    logic [7:0]  wr_data;
  } row_ctl_t;

  localparam logic [7:0] CONT_MASK = 8'hc0;
  localparam logic [7:0] CONT_VAL  = 8'h80;
  localparam logic [7:0] CTRL_MIN  = 8'd32;
  localparam logic [7:0] SPACE_CH  = 8'd32;
  localparam logic [7:0] TAB_CH    = 8'd9;

  function automatic logic is_cont(input logic [7:0] b);
    return (b & CONT_MASK) == CONT_VAL;
  endfunction

  // Rune length from a lead byte; zero marks an invalid lead.
  function automatic logic [2:0] lead_need(input logic [7:0] b);
    logic [2:0] n;
    n = 3'd0;
    if (b < 8'h80) n = 3'd1;
    else if (b >= 8'hc2 && b <= 8'hdf) n = 3'd2;
    else if (b >= 8'he0 && b <= 8'hef) n = 3'd3;
    else if (b >= 8'hf0 && b <= 8'hf4) n = 3'd4;
    return n;
  endfunction

endpackage

FILE: design/ule_cell.sv
// One storage cell of the text row: holds a byte, shifts to either neighbor.
module ule_cell #(
  parameter int PW  = 9,
  parameter int POS = 0
) (
  input  logic             clk,
  input  ule_pkg::row_ctl_t ctl,
  input  logic [7:0]       left_byte,
  input  logic [7:0]       right_byte,
  output logic [7:0]       q
);

  logic [7:0] q_r;
  logic [7:0] q_nxt;
  logic [PW-1:0] my_pos;

  assign my_pos = PW'(POS);
  assign q = q_r;

  // Select the next byte: direct write, neighbor shift or hold.
  always_comb begin
    q_nxt = q_r;
    if (ctl.wr_en && ctl.wr_pos[PW-1:0] == my_pos) begin
      q_nxt = ctl.wr_data;
    end else if (ctl.op == ule_pkg::SH_RIGHT && my_pos > ctl.from_pos[PW-1:0]) begin
      q_nxt = left_byte;
    end else if (ctl.op == ule_pkg::SH_LEFT && my_pos >= ctl.from_pos[PW-1:0]) begin
      q_nxt = right_byte;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule

FILE: design/ule_row.sv
// Row of text cells chained to their neighbors, with per-cell taps.
module ule_row #(
  parameter int DEPTH = 256,
  parameter int PW    = 9
) (
  input  logic             clk,
  input  ule_pkg::row_ctl_t ctl,
  output logic [7:0]       cells [DEPTH]
);

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [7:0] lb;
      logic [7:0] rb;
      if (g == 0) begin : g_l0
        assign lb = 8'd0;
      end else begin : g_ln
        assign lb = cells[g-1];
      end
      if (g == DEPTH - 1) begin : g_r0
        assign rb = 8'd0;
      end else begin : g_rn
        assign rb = cells[g+1];
      end
      ule_cell #(.PW(PW), .POS(g)) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .left_byte (lb),
        .right_byte(rb),
        .q         (cells[g])
      );
    end
  endgenerate

endmodule

FILE: design/utf8_line_edit_buffer_core.sv
// Top level of the UTF-8 line edit buffer: command sequencer over a cell row.
//
//   channel | ports                                           | direction
//   in      | in_valid in_stall in_cmd in_data_byte            | into block
//           | in_last_of_string in_read_index                  |
//   out     | out_valid out_stall out_changed out_cursor_out   | out of block
//           | out_length_out out_read_data                     |
//   cfg     | cfg_we cfg_data                                  | into block
//
// One command at a time. Cursor moves, snaps and trim scans walk the row
// one cell per cycle; a rune insert shifts the tail right once per
// byte, erases shift left once per byte. Reset is synchronous; cell
// contents are not reset. A stalled result holds in the output register
// while the next command already runs.
module utf8_line_edit_buffer_core #(
  parameter int BUF_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] in_cmd,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_of_string,
  input  logic [7:0] in_read_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_changed,
  output logic [8:0] out_cursor_out,
  output logic [8:0] out_length_out,
  output logic [7:0] out_read_data,
  input  logic       cfg_we,
  input  logic [8:0] cfg_data
);

  localparam int PW = $clog2(BUF_DEPTH + 1);
  localparam int IW = $clog2(BUF_DEPTH);
  localparam logic [PW-1:0] DEPTH_P = PW'(BUF_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_SNAP, S_WIN, S_INS, S_PREV, S_NEXT, S_ERASE,
    S_TRIM_S, S_TRIM_E, S_TRIM_SH, S_DONE
  } state_t;

  ule_pkg::row_ctl_t ctl;
  logic [7:0] cells [BUF_DEPTH];

  state_t state_r;
  logic [PW-1:0] len_r, cur_r, pos_r, end_r, cnt_r;
  logic sel_r, mid_r, full_r, schg_r, last_r;
  logic [7:0] win_r [4];
  logic [2:0] wcnt_r, need_r, ins_i_r;
  logic [3:0] cmd_r;
  logic [7:0] ridx_r;
  logic [8:0] lim_r;
  logic chg_r, os_r;
  logic [PW-1:0] oc_r, ol_r;
  logic [7:0] rd_r;
  logic ov_r;
  logic [PW-1:0] lim_eff;
  logic [2:0] need_c;
  logic bad_c, cont_ok;
  logic [PW-1:0] tap_addr;
  logic [7:0] tap;

  ule_row #(.DEPTH(BUF_DEPTH), .PW(PW)) u_row (
    .clk  (clk),
    .ctl  (ctl),
    .cells(cells)
  );

  // Effective limit is the smaller of the register and the row depth.
  assign lim_eff = (32'(lim_r) < 32'(BUF_DEPTH)) ? PW'(lim_r) : DEPTH_P;

  // Pick the one cell the current walk step looks at.
  always_comb begin
    case (state_r)
      S_NEXT:   tap_addr = end_r;
      S_TRIM_E: tap_addr = end_r - 1'b1;
      S_SNAP:   tap_addr = (cmd_r == ule_pkg::CMD_READ) ? PW'(ridx_r) : pos_r;
      default:  tap_addr = pos_r;
    endcase
  end

  assign tap = cells[tap_addr[IW-1:0]];

  // Check the rune window head.
  always_comb begin
    need_c = ule_pkg::lead_need(win_r[0]);
    bad_c = need_c == 3'd0;
    cont_ok = 1'b1;
    if (wcnt_r > 3'd1 && need_c > 3'd1 && !ule_pkg::is_cont(win_r[1])) cont_ok = 1'b0;
    if (wcnt_r > 3'd2 && need_c > 3'd2 && !ule_pkg::is_cont(win_r[2])) cont_ok = 1'b0;
    if (wcnt_r > 3'd3 && need_c > 3'd3 && !ule_pkg::is_cont(win_r[3])) cont_ok = 1'b0;
    if (!cont_ok) bad_c = 1'b1;
    if (!bad_c && wcnt_r >= 3'd2) begin
      if ((need_c == 3'd3 && win_r[0] == 8'he0 && win_r[1] < 8'ha0) ||
          (need_c == 3'd3 && win_r[0] == 8'hed && win_r[1] >= 8'ha0) ||
          (need_c == 3'd4 && win_r[0] == 8'hf0 && win_r[1] < 8'h90) ||
          (need_c == 3'd4 && win_r[0] == 8'hf4 && win_r[1] >= 8'h90)) bad_c = 1'b1;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = ov_r;

  // Drive row control from the sequencer state.
  always_comb begin
    ctl.op = ule_pkg::SH_HOLD;
    ctl.from_pos = '0;
    ctl.wr_en = 1'b0;
    ctl.wr_pos = '0;
    ctl.wr_data = 8'd0;
    if (state_r == S_INS) begin
      if (cnt_r != '0) begin
        ctl.op = ule_pkg::SH_RIGHT;
        ctl.from_pos = 17'(cur_r);
      end else begin
        ctl.wr_en = 1'b1;
        ctl.wr_pos = 17'(cur_r);
        ctl.wr_data = win_r[ins_i_r[1:0]];
      end
    end else if ((state_r == S_ERASE || state_r == S_TRIM_SH) && cnt_r != '0) begin
      ctl.op = ule_pkg::SH_LEFT;
      ctl.from_pos = 17'(pos_r);
    end
  end

  // Sequencer: hold state and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r <= '0; cur_r <= '0; sel_r <= 1'b0;
      mid_r <= 1'b0; full_r <= 1'b0; schg_r <= 1'b0;
      wcnt_r <= '0; lim_r <= 9'd256; ov_r <= 1'b0;
    end else begin
      if (cfg_we) lim_r <= cfg_data;
      if (ov_r && !out_stall && state_r != S_DONE) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r <= in_cmd; last_r <= in_last_of_string; ridx_r <= in_read_index;
            oc_r <= cur_r; os_r <= sel_r; ol_r <= len_r; chg_r <= 1'b0; rd_r <= 8'd0;
            if (in_cmd == ule_pkg::CMD_INSERT) begin
              if (!mid_r) begin
                full_r <= 1'b0; mid_r <= 1'b1;
                win_r[0] <= in_data_byte; wcnt_r <= 3'd1;
                if (sel_r) begin
                  schg_r <= len_r != '0; len_r <= '0; cur_r <= '0; pos_r <= '0;
                  sel_r <= 1'b0;
                end else begin
                  schg_r <= 1'b0;
                  pos_r <= (cur_r > len_r) ? len_r : cur_r;
                end
                state_r <= S_SNAP;
              end else if (!full_r) begin
                win_r[wcnt_r[1:0]] <= in_data_byte;
                wcnt_r <= wcnt_r + 3'd1;
                state_r <= S_WIN;
              end else begin
                state_r <= S_DONE;
              end
            end else begin
              mid_r <= 1'b0; wcnt_r <= '0;
              pos_r <= (cur_r > len_r) ? len_r : cur_r;
              state_r <= S_SNAP;
            end
          end
        end
        // Walk the cursor down to a rune boundary, then dispatch the command.
        S_SNAP: begin
          if (cmd_r != ule_pkg::CMD_READ && pos_r != '0 && pos_r < len_r &&
              ule_pkg::is_cont(tap)) begin
            pos_r <= pos_r - 1'b1;
          end else begin
            case (cmd_r)
              ule_pkg::CMD_INSERT: begin
                cur_r <= pos_r; state_r <= S_WIN;
              end
              ule_pkg::CMD_BACKSPACE: begin
                if (sel_r) begin
                  chg_r <= len_r != '0; len_r <= '0; cur_r <= '0; sel_r <= 1'b0;
                  state_r <= S_DONE;
                end else if (pos_r == '0) begin
                  cur_r <= pos_r; state_r <= S_DONE;
                end else begin
                  end_r <= pos_r; pos_r <= pos_r - 1'b1; state_r <= S_PREV;
                end
              end
              ule_pkg::CMD_DELETE: begin
                if (sel_r) begin
                  chg_r <= len_r != '0; len_r <= '0; cur_r <= '0; sel_r <= 1'b0;
                  state_r <= S_DONE;
                end else if (pos_r >= len_r) begin
                  cur_r <= pos_r; state_r <= S_DONE;
                end else begin
                  end_r <= pos_r + 1'b1; state_r <= S_NEXT;
                end
              end
              ule_pkg::CMD_HOME, ule_pkg::CMD_END, ule_pkg::CMD_LEFT,
              ule_pkg::CMD_RIGHT: begin
                sel_r <= 1'b0;
                if (cmd_r == ule_pkg::CMD_HOME || (os_r && cmd_r == ule_pkg::CMD_LEFT)) begin
                  cur_r <= '0; chg_r <= os_r || oc_r != '0; state_r <= S_DONE;
                end else if (cmd_r == ule_pkg::CMD_END ||
                             (os_r && cmd_r == ule_pkg::CMD_RIGHT)) begin
                  cur_r <= len_r; chg_r <= os_r || oc_r != len_r; state_r <= S_DONE;
                end else if (cmd_r == ule_pkg::CMD_LEFT) begin
                  if (pos_r == '0) begin
                    cur_r <= pos_r; chg_r <= oc_r != '0; state_r <= S_DONE;
                  end else begin
                    end_r <= pos_r; pos_r <= pos_r - 1'b1; state_r <= S_PREV;
                  end
                end else begin
                  if (pos_r >= len_r) begin
                    cur_r <= len_r; chg_r <= oc_r != len_r; state_r <= S_DONE;
                  end else begin
                    end_r <= pos_r + 1'b1; state_r <= S_NEXT;
                  end
                end
              end
              ule_pkg::CMD_BEGIN, ule_pkg::CMD_SELALL: begin
                cur_r <= len_r; sel_r <= cmd_r == ule_pkg::CMD_SELALL;
                chg_r <= oc_r != len_r || os_r != (cmd_r == ule_pkg::CMD_SELALL);
                state_r <= S_DONE;
              end
              ule_pkg::CMD_CLEAR: begin
                chg_r <= len_r != '0 || oc_r != '0 || os_r;
                len_r <= '0; cur_r <= '0; sel_r <= 1'b0; state_r <= S_DONE;
              end
              ule_pkg::CMD_TRIM: begin
                pos_r <= '0; end_r <= len_r; state_r <= S_TRIM_S;
              end
              ule_pkg::CMD_READ: begin
                if (PW'(ridx_r) < len_r) rd_r <= tap;
                state_r <= S_DONE;
              end
              default: begin
                state_r <= S_DONE;
              end
            endcase
          end
        end
        // Step back over continuation bytes; pos_r is the candidate start.
        S_PREV: begin
          if (pos_r != '0 && ule_pkg::is_cont(tap)) begin
            pos_r <= pos_r - 1'b1;
          end else if (cmd_r == ule_pkg::CMD_LEFT) begin
            cur_r <= pos_r; chg_r <= oc_r != pos_r; state_r <= S_DONE;
          end else begin
            cnt_r <= end_r - pos_r; state_r <= S_ERASE;
          end
        end
        // Step forward over continuation bytes; end_r is the candidate end.
        S_NEXT: begin
          if (end_r < len_r && ule_pkg::is_cont(tap)) begin
            end_r <= end_r + 1'b1;
          end else if (cmd_r == ule_pkg::CMD_RIGHT) begin
            cur_r <= end_r; chg_r <= oc_r != end_r; state_r <= S_DONE;
          end else begin
            cnt_r <= end_r - pos_r; state_r <= S_ERASE;
          end
        end
        // Shift the tail left one byte per cycle.
        S_ERASE: begin
          if (cnt_r != '0) begin
            cnt_r <= cnt_r - 1'b1; len_r <= len_r - 1'b1;
          end else begin
            cur_r <= pos_r; chg_r <= 1'b1; state_r <= S_DONE;
          end
        end
        // Check the window head and decide drop, wait, stop or insert.
        S_WIN: begin
          if (wcnt_r == '0) begin
            state_r <= S_DONE;
          end else if (win_r[0] == 8'd0) begin
            full_r <= 1'b1; wcnt_r <= '0; state_r <= S_DONE;
          end else if (!bad_c && wcnt_r < need_c && !last_r) begin
            state_r <= S_DONE;
          end else if (bad_c || wcnt_r < need_c ||
                       (need_c == 3'd1 && win_r[0] < ule_pkg::CTRL_MIN)) begin
            win_r[0] <= win_r[1]; win_r[1] <= win_r[2]; win_r[2] <= win_r[3];
            wcnt_r <= wcnt_r - 3'd1;
          end else if ({1'b0, len_r} + (PW+1)'(need_c) >= {1'b0, lim_eff}) begin
            full_r <= 1'b1; wcnt_r <= '0; state_r <= S_DONE;
          end else begin
            need_r <= need_c; ins_i_r <= '0; cnt_r <= len_r - cur_r;
            state_r <= S_INS;
          end
        end
        // Per rune byte: shift tail right across cells, then write the byte.
        S_INS: begin
          if (cnt_r != '0) begin
            cnt_r <= '0;
          end else begin
            cur_r <= cur_r + 1'b1; len_r <= len_r + 1'b1; schg_r <= 1'b1;
            if (ins_i_r + 3'd1 == need_r) begin
              case (need_r)
                3'd1: begin
                  win_r[0] <= win_r[1]; win_r[1] <= win_r[2]; win_r[2] <= win_r[3];
                end
                3'd2: begin
                  win_r[0] <= win_r[2]; win_r[1] <= win_r[3];
                end
                3'd3: win_r[0] <= win_r[3];
                default: ;
              endcase
              wcnt_r <= wcnt_r - need_r;
              state_r <= S_WIN;
            end else begin
              ins_i_r <= ins_i_r + 3'd1;
              cnt_r <= len_r - cur_r;
            end
          end
        end
        // Find first byte that is not space or tab.
        S_TRIM_S: begin
          if (pos_r < end_r && (tap == ule_pkg::SPACE_CH || tap == ule_pkg::TAB_CH)) begin
            pos_r <= pos_r + 1'b1;
          end else begin
            state_r <= S_TRIM_E;
          end
        end
        // Trim trailing blanks, then shift out the leading ones.
        S_TRIM_E: begin
          if (end_r > pos_r && (tap == ule_pkg::SPACE_CH || tap == ule_pkg::TAB_CH)) begin
            end_r <= end_r - 1'b1;
          end else begin
            len_r <= end_r; cnt_r <= pos_r; pos_r <= '0; state_r <= S_TRIM_SH;
          end
        end
        S_TRIM_SH: begin
          if (cnt_r != '0) begin
            cnt_r <= cnt_r - 1'b1; len_r <= len_r - 1'b1;
          end else begin
            chg_r <= len_r != ol_r;
            state_r <= S_DONE;
          end
        end
        // Present the result once the output register is free.
        S_DONE: begin
          if (!ov_r || !out_stall) begin
            ov_r <= 1'b1;
            out_cursor_out <= 9'(cur_r);
            out_length_out <= 9'(len_r);
            out_read_data <= rd_r;
            if (cmd_r == ule_pkg::CMD_INSERT) begin
              out_changed <= schg_r;
              if (last_r) begin
                mid_r <= 1'b0; wcnt_r <= '0;
              end
            end else begin
              out_changed <= chg_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: tb/ule_checker.sv
// Checker for the UTF-8 line edit buffer: predicts each result and compares it.
`timescale 1ns / 100ps

module ule_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [3:0] in_cmd,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_of_string,
  input  logic [7:0] in_read_index,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       out_changed,
  input  logic [8:0] out_cursor_out,
  input  logic [8:0] out_length_out,
  input  logic [7:0] out_read_data,
  input  logic       cfg_we,
  input  logic [8:0] cfg_data,
  output int         fail_count,
  output int         pending
);

  localparam int DEPTH = 256;

  typedef struct packed {
    logic       changed;
    logic [8:0] cursor;
    logic [8:0] length;
    logic [7:0] rdata;
  } edit_result_t;

  // Mirror of the line buffer
  logic [7:0] text_mem [DEPTH];
  int         text_len;
  int         cur_pos;
  bit         sel_all;
  logic [7:0] rune_buf [4];
  int         rune_cnt;
  bit         in_string;
  bit         string_stop;
  bit         string_chg;
  int         limit_reg;

  edit_result_t expected_q[$];

  function automatic bit cont_byte(input logic [7:0] b);
    return (b & ule_pkg::CONT_MASK) == ule_pkg::CONT_VAL;
  endfunction

  function automatic int snap_pos(input int c);
    if (c > text_len) c = text_len;
    while (c != 0 && c < text_len && cont_byte(text_mem[c])) c--;
    return c;
  endfunction

  function automatic int prev_pos(input int c);
    c = snap_pos(c);
    if (c == 0) return 0;
    do c--; while (c != 0 && cont_byte(text_mem[c]));
    return c;
  endfunction

  function automatic int next_pos(input int c);
    c = snap_pos(c);
    if (c >= text_len) return text_len;
    do c++; while (c < text_len && cont_byte(text_mem[c]));
    return c;
  endfunction

  function automatic void drop_rune_bytes(input int n);
    for (int i = 0; i + n < rune_cnt; i++) rune_buf[i] = rune_buf[i + n];
    rune_cnt -= n;
  endfunction

  function automatic void erase_span(input int s, input int e);
    for (int i = e; i < text_len; i++) text_mem[s + (i - e)] = text_mem[i];
    text_len -= e - s;
  endfunction

  // Validate and insert whole runes from the pending bytes
  function automatic void place_runes(input bit last);
    int         lim;
    int         need;
    bit         bad;
    logic [7:0] lead;
    logic [7:0] b1;
    lim = (limit_reg < DEPTH) ? limit_reg : DEPTH;
    while (rune_cnt != 0) begin
      lead = rune_buf[0];
      if (lead == 8'h00) begin
        string_stop = 1'b1;
        rune_cnt = 0;
        return;
      end
      if (lead < 8'h80) need = 1;
      else if (lead >= 8'hc2 && lead <= 8'hdf) need = 2;
      else if (lead >= 8'he0 && lead <= 8'hef) need = 3;
      else if (lead >= 8'hf0 && lead <= 8'hf4) need = 4;
      else need = 0;
      bad = (need == 0);
      for (int i = 1; i < rune_cnt && i < need; i++)
        if (!cont_byte(rune_buf[i])) bad = 1'b1;
      if (!bad && rune_cnt >= 2) begin
        b1 = rune_buf[1];
        if ((need == 3 && lead == 8'he0 && b1 < 8'ha0) ||
            (need == 3 && lead == 8'hed && b1 >= 8'ha0) ||
            (need == 4 && lead == 8'hf0 && b1 < 8'h90) ||
            (need == 4 && lead == 8'hf4 && b1 >= 8'h90)) bad = 1'b1;
      end
      if (!bad && rune_cnt < need) begin
        if (!last) return;
        bad = 1'b1;
      end
      if (bad || (need == 1 && lead < ule_pkg::CTRL_MIN)) begin
        drop_rune_bytes(1);
        continue;
      end
      if (text_len + need >= lim) begin
        string_stop = 1'b1;
        rune_cnt = 0;
        return;
      end
      for (int i = text_len; i > cur_pos; i--) text_mem[i - 1 + need] = text_mem[i - 1];
      for (int i = 0; i < need; i++) text_mem[cur_pos + i] = rune_buf[i];
      cur_pos += need;
      text_len += need;
      string_chg = 1'b1;
      drop_rune_bytes(need);
    end
  endfunction

  function automatic edit_result_t edit_step(input logic [3:0] cmd, input logic [7:0] data,
                                             input bit last, input logic [7:0] ridx);
    edit_result_t r;
    bit           chg;
    int           old_cur;
    int           old_len;
    bit           old_sel;
    int           c;
    int           s;
    int           e;
    chg = 1'b0;
    r.rdata = 8'h00;
    old_cur = cur_pos;
    old_len = text_len;
    old_sel = sel_all;
    if (cmd == ule_pkg::CMD_INSERT) begin
      if (!in_string) begin
        string_chg = 1'b0;
        string_stop = 1'b0;
        rune_cnt = 0;
        if (sel_all) begin
          string_chg = (text_len != 0);
          text_len = 0;
          cur_pos = 0;
          sel_all = 1'b0;
        end
        cur_pos = snap_pos(cur_pos);
        in_string = 1'b1;
      end
      if (!string_stop) begin
        rune_buf[rune_cnt & 3] = data;
        rune_cnt++;
        place_runes(last);
      end
      if (last) begin
        in_string = 1'b0;
        rune_cnt = 0;
      end
      chg = string_chg;
    end else begin
      in_string = 1'b0;
      rune_cnt = 0;
      case (cmd)
        ule_pkg::CMD_BACKSPACE, ule_pkg::CMD_DELETE: begin
          if (sel_all) begin
            chg = (text_len != 0);
            text_len = 0;
            cur_pos = 0;
            sel_all = 1'b0;
          end else begin
            c = snap_pos(cur_pos);
            cur_pos = c;
            s = (cmd == ule_pkg::CMD_DELETE) ? c : prev_pos(c);
            e = (cmd == ule_pkg::CMD_DELETE) ? next_pos(c) : c;
            if (s != e) begin
              erase_span(s, e);
              cur_pos = s;
              chg = 1'b1;
            end
          end
        end
        ule_pkg::CMD_HOME, ule_pkg::CMD_END, ule_pkg::CMD_LEFT, ule_pkg::CMD_RIGHT: begin
          c = snap_pos(cur_pos);
          if (cmd == ule_pkg::CMD_HOME || (old_sel && cmd == ule_pkg::CMD_LEFT)) c = 0;
          else if (cmd == ule_pkg::CMD_END || (old_sel && cmd == ule_pkg::CMD_RIGHT))
            c = text_len;
          else if (cmd == ule_pkg::CMD_LEFT) c = prev_pos(c);
          else c = next_pos(c);
          cur_pos = c;
          sel_all = 1'b0;
          chg = old_sel || (old_cur != c);
        end
        ule_pkg::CMD_BEGIN, ule_pkg::CMD_SELALL: begin
          cur_pos = text_len;
          sel_all = (cmd == ule_pkg::CMD_SELALL);
          chg = (old_cur != cur_pos) || (old_sel != sel_all);
        end
        ule_pkg::CMD_CLEAR: begin
          text_len = 0;
          cur_pos = 0;
          sel_all = 1'b0;
          chg = (old_len != 0) || (old_cur != 0) || old_sel;
        end
        ule_pkg::CMD_TRIM: begin
          s = 0;
          e = text_len;
          while (s < e && (text_mem[s] == ule_pkg::SPACE_CH ||
                           text_mem[s] == ule_pkg::TAB_CH)) s++;
          while (e > s && (text_mem[e-1] == ule_pkg::SPACE_CH ||
                           text_mem[e-1] == ule_pkg::TAB_CH)) e--;
          text_len = e;
          erase_span(0, s);
          chg = (text_len != old_len);
        end
        ule_pkg::CMD_READ: begin
          if (ridx < text_len) r.rdata = text_mem[ridx];
        end
        default: ;
      endcase
    end
    r.changed = chg;
    r.cursor = cur_pos[8:0];
    r.length = text_len[8:0];
    return r;
  endfunction

  // Track transactions on all three ports
  always @(posedge clk) begin
    edit_result_t exp_r;
    if (!rst_n) begin
      text_len = 0;
      cur_pos = 0;
      sel_all = 1'b0;
      rune_cnt = 0;
      in_string = 1'b0;
      string_stop = 1'b0;
      string_chg = 1'b0;
      limit_reg = 256;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) limit_reg = cfg_data;
      if (in_valid && !in_stall)
        expected_q.push_back(edit_step(in_cmd, in_data_byte, in_last_of_string,
                                       in_read_index));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("ERROR: unexpected result transaction");
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_changed !== exp_r.changed || out_cursor_out !== exp_r.cursor ||
              out_length_out !== exp_r.length || out_read_data !== exp_r.rdata) begin
            if (fail_count < 10)
              $display({"ERROR: exp chg=%0d cur=%0d len=%0d rd=%02h, ",
                        "got chg=%0d cur=%0d len=%0d rd=%02h"},
                       exp_r.changed, exp_r.cursor, exp_r.length, exp_r.rdata,
                       out_changed, out_cursor_out, out_length_out, out_read_data);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

FILE: tb/tb_utf8_line_edit_buffer_core.sv
// Testbench top for the UTF-8 line edit buffer: stimulus, stalls and verdict.
`timescale 1ns / 100ps

module tb_utf8_line_edit_buffer_core;

  localparam int         DRAIN_CYCLES = 600;
  localparam logic [3:0] CMD_SPARE_LO = 4'd12;
  localparam logic [3:0] CMD_SPARE_HI = 4'd15;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [3:0] in_cmd;
  logic [7:0] in_data_byte;
  logic       in_last_of_string;
  logic [7:0] in_read_index;
  logic       out_valid;
  logic       out_stall;
  logic       out_changed;
  logic [8:0] out_cursor_out;
  logic [8:0] out_length_out;
  logic [7:0] out_read_data;
  logic       cfg_we;
  logic [8:0] cfg_data;
  int         fail_count;
  int         pending;
  bit         no_gaps;
  int         stall_left = 0;
  logic [7:0] rune_q[$];

  utf8_line_edit_buffer_core dut (.*);

  ule_checker chk (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver: random stall after each result transaction
  always @(posedge clk) begin
    if (out_valid && !out_stall) stall_left = no_gaps ? 0 : $urandom_range(0, 11);
    out_stall <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  initial begin
    #50ms;
    $display("utf8_line_edit_buffer_core test failed");
    $finish;
  end

  // Hold valid high until the transaction is accepted
  task automatic send_item(input logic [3:0] cmd, input logic [7:0] data,
                           input bit last, input logic [7:0] ridx);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_data_byte <= data;
    in_last_of_string <= last;
    in_read_index <= ridx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_cmd(input logic [3:0] cmd);
    send_item(cmd, 8'($urandom), 1'($urandom), 8'($urandom));
  endtask

  // Send the queued bytes as one string; optionally cut it off unterminated
  task automatic send_string(input bit terminate);
    for (int i = 0; i < rune_q.size(); i++)
      send_item(ule_pkg::CMD_INSERT, rune_q[i], terminate && (i == rune_q.size() - 1),
                8'($urandom));
    rune_q.delete();
  endtask

  function automatic logic [7:0] cont_rand();
    return 8'($urandom_range(8'h80, 8'hbf));
  endfunction

  // Queue one rune: mostly valid, sometimes malformed
  function automatic void add_rune();
    logic [7:0] lead;
    case ($urandom_range(0, 11))
      0, 1, 2: rune_q.push_back(8'($urandom_range(33, 126)));
      3: rune_q.push_back($urandom_range(0, 1) ? ule_pkg::SPACE_CH : ule_pkg::TAB_CH);
      4: begin
        rune_q.push_back(8'($urandom_range(8'hc2, 8'hdf)));
        rune_q.push_back(cont_rand());
      end
      5: begin
        lead = 8'($urandom_range(8'he0, 8'hef));
        rune_q.push_back(lead);
        rune_q.push_back(lead == 8'he0 ? 8'($urandom_range(8'ha0, 8'hbf)) :
                         lead == 8'hed ? 8'($urandom_range(8'h80, 8'h9f)) : cont_rand());
        rune_q.push_back(cont_rand());
      end
      6: begin
        lead = 8'($urandom_range(8'hf0, 8'hf4));
        rune_q.push_back(lead);
        rune_q.push_back(lead == 8'hf0 ? 8'($urandom_range(8'h90, 8'hbf)) :
                         lead == 8'hf4 ? 8'($urandom_range(8'h80, 8'h8f)) : cont_rand());
        rune_q.push_back(cont_rand());
        rune_q.push_back(cont_rand());
      end
      7: rune_q.push_back(8'($urandom_range(0, 31)));
      8: rune_q.push_back(8'($urandom));
      9: begin
        // truncated or limit-breaking multibyte rune
        rune_q.push_back(8'($urandom_range(8'hc0, 8'hff)));
        if ($urandom_range(0, 1)) rune_q.push_back(cont_rand());
      end
      10: if ($urandom_range(0, 3) == 0) rune_q.push_back(8'h00);
          else rune_q.push_back(cont_rand());
      default: begin
        rune_q.push_back(8'($urandom_range(8'hc2, 8'hdf)));
        rune_q.push_back(cont_rand());
      end
    endcase
  endfunction

  // Drain all results, then let the block settle before a register write
  task automatic drain_and_set(input logic [8:0] lim);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= lim;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [8:0] limits[8];
    int         sent;
    int         wait_cnt;
    limits = '{9'd256, 9'd1, 9'd0, 9'd2, 9'd12, 9'd40, 9'd300, 9'd511};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = ule_pkg::CMD_READ;
    in_data_byte = 8'h00;
    in_last_of_string = 1'b0;
    in_read_index = 8'h00;
    cfg_we = 1'b0;
    cfg_data = 9'd256;
    no_gaps = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: valid runes, malformed runes, edits and moves
    rune_q = '{8'h41, 8'he2, 8'h82, 8'hac, 8'hf0, 8'h9f, 8'h98, 8'h80};
    send_string(1'b1);
    rune_q = '{8'hff, 8'h01, 8'he0, 8'h80, 8'hed, 8'ha0, 8'hf4, 8'h90, 8'hc3};
    send_string(1'b1);
    rune_q = '{8'h20, 8'h7f, 8'h00, 8'h42};
    send_string(1'b1);
    send_cmd(ule_pkg::CMD_LEFT);
    send_cmd(ule_pkg::CMD_BACKSPACE);
    send_cmd(ule_pkg::CMD_HOME);
    send_cmd(ule_pkg::CMD_DELETE);
    send_cmd(ule_pkg::CMD_RIGHT);
    send_cmd(ule_pkg::CMD_END);
    send_item(ule_pkg::CMD_READ, 8'h00, 1'b0, 8'd0);
    send_item(ule_pkg::CMD_READ, 8'h00, 1'b0, 8'd255);
    send_cmd(ule_pkg::CMD_SELALL);
    send_cmd(ule_pkg::CMD_RIGHT);
    send_cmd(ule_pkg::CMD_SELALL);
    rune_q = '{8'h09, 8'h20, 8'h43, 8'h20};
    send_string(1'b1);
    send_cmd(ule_pkg::CMD_TRIM);
    send_cmd(ule_pkg::CMD_BEGIN);
    send_cmd(ule_pkg::CMD_SELALL);
    send_cmd(ule_pkg::CMD_DELETE);
    send_cmd(CMD_SPARE_HI);
    send_cmd(ule_pkg::CMD_CLEAR);

    // Random phases, one per buffer limit
    foreach (limits[p]) begin
      drain_and_set(limits[p]);
      sent = 0;
      while (sent < 225) begin
        if ($urandom_range(0, 15) == 0) no_gaps = ~no_gaps;
        if ($urandom_range(0, 9) < 5) begin
          wait_cnt = $urandom_range(1, 6);
          repeat (wait_cnt) add_rune();
          sent += rune_q.size();
          send_string($urandom_range(0, 9) != 0);
        end else if ($urandom_range(0, 19) == 0) begin
          send_cmd(4'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)));
          sent++;
        end else begin
          send_cmd(4'($urandom_range(ule_pkg::CMD_BACKSPACE, ule_pkg::CMD_READ)));
          sent++;
        end
      end
    end
    no_gaps = 1'b0;

    in_valid <= 1'b0;
    wait_cnt = 0;
    @(posedge clk);
    while (pending != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending == 0 && fail_count == 0) begin
      $display("utf8_line_edit_buffer_core test passed");
    end else begin
      $display("utf8_line_edit_buffer_core test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/ule_pkg.sv
design/ule_cell.sv
design/ule_row.sv
design/utf8_line_edit_buffer_core.sv
tb/ule_checker.sv
tb/tb_utf8_line_edit_buffer_core.sv
